/* rtl/core/adp_pkg.sv */
// Shared types, constants and microcode ROM for the ADP advertise scheduler.
// No dependencies; imported by every module of the block.
`default_nettype none

package adp_pkg;

    // Table geometry
    localparam int ENTRIES  = 8;
    localparam int IDX_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int MAX_RES  = 8;
    localparam int NRES_W   = $clog2(MAX_RES + 1);

    // Field widths
    localparam int FUNC_W   = 3;
    localparam int ID_W     = 64;
    localparam int VT_W     = 5;
    localparam int KIND_W   = 2;
    localparam int LFSR_W   = 16;
    localparam int CD_W     = 15;
    localparam int RANGE_W  = 14;
    localparam int MODC_W   = $clog2(LFSR_W + 1);

    // Arithmetic constants (ms)
    localparam int RANGE_MUL = 1000 * 2 / 5;
    localparam int BASE_MUL  = 1000 / 2;
    localparam int BASE_MIN  = 1000;

    localparam logic [LFSR_W-1:0] SEED_RESET = 16'hACE1;
    localparam logic [LFSR_W-1:0] LFSR_TAPS  = 16'hB400;

    // Configuration port
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_SEED = 1'b0;

    // Function codes
    localparam logic [FUNC_W-1:0] FN_TICK     = 3'd0;
    localparam logic [FUNC_W-1:0] FN_ENABLE   = 3'd1;
    localparam logic [FUNC_W-1:0] FN_DISABLE  = 3'd2;
    localparam logic [FUNC_W-1:0] FN_READV    = 3'd3;
    localparam logic [FUNC_W-1:0] FN_DISCOVER = 3'd4;

    // Message kinds
    localparam logic [KIND_W-1:0] KIND_NONE   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_AVAIL  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DEPART = 2'd2;
    localparam logic [KIND_W-1:0] KIND_FULL   = 2'd3;

    // Microcode
    localparam int PC_W = 5;

    typedef enum logic [3:0] {
        A_NOP,
        A_ACCEPT,
        A_INC_IDX,
        A_DEC,
        A_EMIT_AV,
        A_DRAW,
        A_RELOAD,
        A_LOAD_RAND,
        A_SCAN,
        A_INSERT,
        A_EMIT_FULL,
        A_EMIT_DEP
    } action_t;

    typedef enum logic [1:0] {
        W_NONE,
        W_IN,
        W_OUT,
        W_DIV
    } wait_t;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_F_TICK,
        C_F_EN,
        C_F_DIS,
        C_F_RS,
        C_DUE,
        C_LAST,
        C_RS_SKIP,
        C_HIT,
        C_FOUND,
        C_NO_FREE
    } cond_t;

    typedef struct packed {
        action_t         action;
        wait_t           wt;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } ctrl_t;

    typedef struct packed {
        logic item_valid;
        logic out_free;
        logic div_busy;
        logic f_tick;
        logic f_en;
        logic f_dis;
        logic f_rs;
        logic due;
        logic last_slot;
        logic rs_skip;
        logic hit;
        logic found;
        logic no_free;
    } status_t;

    // Program entry points
    localparam logic [PC_W-1:0] PC_IDLE    = 5'd0;
    localparam logic [PC_W-1:0] PC_TICK    = 5'd6;
    localparam logic [PC_W-1:0] PC_AV      = 5'd9;
    localparam logic [PC_W-1:0] PC_RS      = 5'd14;
    localparam logic [PC_W-1:0] PC_RS_NEXT = 5'd18;
    localparam logic [PC_W-1:0] PC_EN      = 5'd20;
    localparam logic [PC_W-1:0] PC_EN_DONE = 5'd22;
    localparam logic [PC_W-1:0] PC_FULL    = 5'd25;
    localparam logic [PC_W-1:0] PC_DIS     = 5'd26;
    localparam logic [PC_W-1:0] PC_DIS_HIT = 5'd29;

    function automatic ctrl_t mk(action_t a, wait_t w, cond_t c, logic [PC_W-1:0] t);
        ctrl_t cw;
        cw.action = a;
        cw.wt     = w;
        cw.cond   = c;
        cw.target = t;
        return cw;
    endfunction

    // Control store: condition true -> target, else pc + 1
    function automatic ctrl_t ucode_word(logic [PC_W-1:0] pc);
        ctrl_t cw;
        case (pc)
            // dispatch
            5'd0:  cw = mk(A_ACCEPT,    W_IN,   C_NEVER,   PC_IDLE);
            5'd1:  cw = mk(A_NOP,       W_NONE, C_F_TICK,  PC_TICK);
            5'd2:  cw = mk(A_NOP,       W_NONE, C_F_EN,    PC_EN);
            5'd3:  cw = mk(A_NOP,       W_NONE, C_F_DIS,   PC_DIS);
            5'd4:  cw = mk(A_NOP,       W_NONE, C_F_RS,    PC_RS);
            5'd5:  cw = mk(A_NOP,       W_NONE, C_ALWAYS,  PC_IDLE);
            // tick scan
            5'd6:  cw = mk(A_NOP,       W_NONE, C_DUE,     PC_AV);
            5'd7:  cw = mk(A_DEC,       W_NONE, C_LAST,    PC_IDLE);
            5'd8:  cw = mk(A_INC_IDX,   W_NONE, C_ALWAYS,  PC_TICK);
            5'd9:  cw = mk(A_EMIT_AV,   W_OUT,  C_NEVER,   PC_IDLE);
            5'd10: cw = mk(A_DRAW,      W_NONE, C_NEVER,   PC_IDLE);
            5'd11: cw = mk(A_NOP,       W_DIV,  C_NEVER,   PC_IDLE);
            5'd12: cw = mk(A_RELOAD,    W_NONE, C_LAST,    PC_IDLE);
            5'd13: cw = mk(A_INC_IDX,   W_NONE, C_ALWAYS,  PC_TICK);
            // readvertise / discover
            5'd14: cw = mk(A_NOP,       W_NONE, C_RS_SKIP, PC_RS_NEXT);
            5'd15: cw = mk(A_DRAW,      W_NONE, C_NEVER,   PC_IDLE);
            5'd16: cw = mk(A_NOP,       W_DIV,  C_NEVER,   PC_IDLE);
            5'd17: cw = mk(A_LOAD_RAND, W_NONE, C_NEVER,   PC_IDLE);
            5'd18: cw = mk(A_NOP,       W_NONE, C_LAST,    PC_IDLE);
            5'd19: cw = mk(A_INC_IDX,   W_NONE, C_ALWAYS,  PC_RS);
            // enable
            5'd20: cw = mk(A_SCAN,      W_NONE, C_LAST,    PC_EN_DONE);
            5'd21: cw = mk(A_INC_IDX,   W_NONE, C_ALWAYS,  PC_EN);
            5'd22: cw = mk(A_NOP,       W_NONE, C_FOUND,   PC_IDLE);
            5'd23: cw = mk(A_NOP,       W_NONE, C_NO_FREE, PC_FULL);
            5'd24: cw = mk(A_INSERT,    W_NONE, C_ALWAYS,  PC_IDLE);
            5'd25: cw = mk(A_EMIT_FULL, W_OUT,  C_ALWAYS,  PC_IDLE);
            // disable
            5'd26: cw = mk(A_NOP,       W_NONE, C_HIT,     PC_DIS_HIT);
            5'd27: cw = mk(A_NOP,       W_NONE, C_LAST,    PC_IDLE);
            5'd28: cw = mk(A_INC_IDX,   W_NONE, C_ALWAYS,  PC_DIS);
            5'd29: cw = mk(A_EMIT_DEP,  W_OUT,  C_ALWAYS,  PC_IDLE);
            default: cw = mk(A_NOP,     W_NONE, C_ALWAYS,  PC_IDLE);
        endcase
        return cw;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/adp_advertise_scheduler_core.sv */
// Top level of the ADP advertise scheduler: APB seed register and block wiring.
// Depends on adp_pkg, adp_seq, adp_slot_dp (with adp_mod_unit).
`default_nettype none

// ADP advertise scheduler. Keeps a table of ENTRIES (8) advertised entities,
// each with its id, valid time and a millisecond countdown. Transactions on
// the item channel: tick (func 0, one per millisecond), enable (1), disable
// (2), readvertise (3) and discover (4); entity_id 0 on readvertise/discover
// targets every entity. A tick emits "available" for each due entry in slot
// order and reloads it with max(1000, valid_time*500) ms plus a random delay
// of lfsr mod (valid_time*400) ms; a zero valid time gives zero delay.
// Disable emits "departing" and frees the slot; enable of a new id into a full
// table emits "table full". last_result marks the final result of a transaction.
// The block is driven by a microcoded sequencer: a 30-word control store steps
// a plain datapath one slot at a time. Items are handled one at a time;
// item_stall is low only in the dispatch step. After the accept, dispatch
// branches on the function code; an unused code returns to the accept step.
// A tick or readvertise/discover scan walks every slot in turn. Each due entry,
// and each slot hit by a readvertise/discover, waits on the bit-serial 16-step
// modulo unit that draws the random delay. Enable scans all slots before it
// inserts the id or reports a full table; disable scans until the slot that
// holds the id, or to the last slot. Results leave through a one-deep output
// register; the sequencer waits at an emit step only while that register is
// occupied and stalled.
// random_seed sits at byte address 0 of the APB port; writing it also loads
// the LFSR. Write it only while the block is idle.

module adp_advertise_scheduler_core (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    // configuration
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [adp_pkg::PADDR_W-1:0] paddr,
    input  wire logic [adp_pkg::PDATA_W-1:0] pwdata,
    output logic [adp_pkg::PDATA_W-1:0]      prdata,
    output logic                             pready,
    // item channel
    input  wire logic                        item_valid,
    output logic                             item_stall,
    input  wire logic [adp_pkg::FUNC_W-1:0]  func,
    input  wire logic [adp_pkg::ID_W-1:0]    entity_id,
    input  wire logic [adp_pkg::VT_W-1:0]    valid_time,
    // result channel
    output logic                             result_valid,
    input  wire logic                        result_stall,
    output logic [adp_pkg::KIND_W-1:0]       message_kind,
    output logic [adp_pkg::ID_W-1:0]         out_entity_id,
    output logic [adp_pkg::VT_W-1:0]         out_valid_time,
    output logic                             last_result
);
    import adp_pkg::*;

    logic [LFSR_W-1:0] seed_reg;
    logic              reg_sel;
    logic              seed_wr;
    ctrl_t             ctrl;
    status_t           st;
    logic              step;

    // APB: single register, word aligned; pready tied high
    assign reg_sel = paddr[PADDR_W-1];
    assign seed_wr = psel && penable && pwrite && (reg_sel == REG_SEED);
    assign pready  = 1'b1;
    assign prdata  = (reg_sel == REG_SEED) ? PDATA_W'(seed_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seed_reg <= SEED_RESET;
        else if (seed_wr)
            seed_reg <= pwdata[LFSR_W-1:0];
    end

    // the dispatch word is the only step that takes an item
    assign item_stall = (ctrl.action != A_ACCEPT);

    adp_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .st    (st),
        .ctrl  (ctrl),
        .step  (step)
    );

    adp_slot_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (ctrl),
        .step           (step),
        .item_valid     (item_valid),
        .func           (func),
        .entity_id      (entity_id),
        .valid_time     (valid_time),
        .seed_wr        (seed_wr),
        .seed_val       (pwdata[LFSR_W-1:0]),
        .result_stall   (result_stall),
        .st             (st),
        .result_valid   (result_valid),
        .message_kind   (message_kind),
        .out_entity_id  (out_entity_id),
        .out_valid_time (out_valid_time),
        .last_result    (last_result)
    );

endmodule

`default_nettype wire

/* rtl/core/adp_mod_unit.sv */
// Bit-serial restoring modulo unit: LFSR value mod random range.
// Depends on adp_pkg.
`default_nettype none

module adp_mod_unit (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [adp_pkg::LFSR_W-1:0]  dividend,
    input  wire logic [adp_pkg::RANGE_W-1:0] divisor,
    output logic                             busy,
    output logic [adp_pkg::RANGE_W-1:0]     remainder
);
    import adp_pkg::*;

    logic [MODC_W-1:0]  cnt_reg, cnt_next;
    logic [LFSR_W-1:0]  q_reg;
    logic [RANGE_W-1:0] r_reg;
    logic [RANGE_W-1:0] d_reg;
    logic               zero_reg;

    logic [RANGE_W:0]   trial;
    logic [RANGE_W:0]   diff;
    logic [RANGE_W-1:0] r_step;

    always_comb
    begin
        trial  = {r_reg, q_reg[LFSR_W-1]};
        diff   = trial - {1'b0, d_reg};
        // remainder stays below divisor, so both fit RANGE_W bits
        r_step = (trial >= {1'b0, d_reg}) ? diff[RANGE_W-1:0] : trial[RANGE_W-1:0];
        if (start)
            cnt_next = MODC_W'(LFSR_W);
        else if (cnt_reg != '0)
            cnt_next = cnt_reg - 1'b1;
        else
            cnt_next = cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg    <= dividend;
            r_reg    <= '0;
            d_reg    <= divisor;
            zero_reg <= (divisor == '0);
        end
        else if (cnt_reg != '0)
        begin
            q_reg <= {q_reg[LFSR_W-2:0], 1'b0};
            r_reg <= r_step;
        end
    end

    assign busy      = (cnt_reg != '0);
    assign remainder = zero_reg ? '0 : r_reg;

endmodule

`default_nettype wire

/* rtl/core/adp_seq.sv */
// Microcode sequencer: step counter, control store lookup, waits and branches.
// Depends on adp_pkg (ucode_word, ctrl_t, status_t).
`default_nettype none

module adp_seq (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire adp_pkg::status_t st,
    output adp_pkg::ctrl_t        ctrl,
    output logic                  step
);
    import adp_pkg::*;

    logic [PC_W-1:0] pc_reg, pc_next;
    logic            hold;
    logic            taken;

    always_comb
    begin
        ctrl = ucode_word(pc_reg);

        case (ctrl.wt)
            W_NONE:  hold = 1'b0;
            W_IN:    hold = !st.item_valid;
            W_OUT:   hold = !st.out_free;
            W_DIV:   hold = st.div_busy;
            default: hold = 1'b0;
        endcase

        case (ctrl.cond)
            C_NEVER:   taken = 1'b0;
            C_ALWAYS:  taken = 1'b1;
            C_F_TICK:  taken = st.f_tick;
            C_F_EN:    taken = st.f_en;
            C_F_DIS:   taken = st.f_dis;
            C_F_RS:    taken = st.f_rs;
            C_DUE:     taken = st.due;
            C_LAST:    taken = st.last_slot;
            C_RS_SKIP: taken = st.rs_skip;
            C_HIT:     taken = st.hit;
            C_FOUND:   taken = st.found;
            C_NO_FREE: taken = st.no_free;
            default:   taken = 1'b0;
        endcase

        step = !hold;
        if (hold)
            pc_next = pc_reg;
        else if (taken)
            pc_next = ctrl.target;
        else
            pc_next = pc_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= PC_IDLE;
        else
            pc_reg <= pc_next;
    end

endmodule

`default_nettype wire

/* rtl/core/adp_slot_dp.sv */
// Datapath: slot table, scan index, LFSR, reload arithmetic, result register.
// Depends on adp_pkg and adp_mod_unit; driven by adp_seq control words.
`default_nettype none

module adp_slot_dp (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire adp_pkg::ctrl_t             ctrl,
    input  wire logic                       step,
    input  wire logic                       item_valid,
    input  wire logic [adp_pkg::FUNC_W-1:0] func,
    input  wire logic [adp_pkg::ID_W-1:0]   entity_id,
    input  wire logic [adp_pkg::VT_W-1:0]   valid_time,
    input  wire logic                       seed_wr,
    input  wire logic [adp_pkg::LFSR_W-1:0] seed_val,
    input  wire logic                       result_stall,
    output adp_pkg::status_t                st,
    output logic                            result_valid,
    output logic [adp_pkg::KIND_W-1:0]      message_kind,
    output logic [adp_pkg::ID_W-1:0]        out_entity_id,
    output logic [adp_pkg::VT_W-1:0]        out_valid_time,
    output logic                            last_result
);
    import adp_pkg::*;

    // slot table
    logic [ENTRIES-1:0] slot_used_reg;
    logic [ID_W-1:0]    slot_entity_reg [ENTRIES];
    logic [VT_W-1:0]    slot_vt_reg     [ENTRIES];
    logic [CD_W-1:0]    slot_cd_reg     [ENTRIES];

    // transaction capture and scan state
    logic [FUNC_W-1:0]  func_reg;
    logic [ID_W-1:0]    id_reg;
    logic [VT_W-1:0]    vt_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [NRES_W-1:0]  nres_reg;
    logic               found_reg;
    logic               free_found_reg;
    logic [IDX_W-1:0]   free_idx_reg;
    logic [LFSR_W-1:0]  lfsr_reg;

    // result register
    logic               res_valid_reg;
    logic [KIND_W-1:0]  res_kind_reg;
    logic [ID_W-1:0]    res_id_reg;
    logic [VT_W-1:0]    res_vt_reg;
    logic               res_last_reg;

    action_t            act;
    logic               u_cur;
    logic [ID_W-1:0]    e_cur;
    logic [VT_W-1:0]    vt_cur;
    logic [CD_W-1:0]    cd_cur;
    logic [ENTRIES-1:0] due_mask;
    logic               later_due;
    logic               av_last;
    logic               match;
    logic [LFSR_W-1:0]  lfsr_step;
    logic [RANGE_W-1:0] range_cur;
    logic [RANGE_W-1:0] base_mul;
    logic [RANGE_W-1:0] base;
    logic [CD_W-1:0]    reload;
    logic               div_busy;
    logic [RANGE_W-1:0] rnd;
    logic [IDX_W-1:0]   wr_idx;
    logic               out_free;

    always_comb
    begin
        act    = step ? ctrl.action : A_NOP;
        u_cur  = slot_used_reg[idx_reg];
        e_cur  = slot_entity_reg[idx_reg];
        vt_cur = slot_vt_reg[idx_reg];
        cd_cur = slot_cd_reg[idx_reg];

        // due slots ahead of the scan decide whether this result closes the tick
        later_due = 1'b0;
        for (int j = 0; j < ENTRIES; j++)
        begin
            due_mask[j] = slot_used_reg[j] && (slot_cd_reg[j] == '0);
            if (IDX_W'(j) > idx_reg)
                later_due = later_due | due_mask[j];
        end
        av_last = (nres_reg == NRES_W'(MAX_RES - 1)) || !later_due;

        match     = u_cur && (e_cur == id_reg);
        lfsr_step = (lfsr_reg >> 1) ^ (lfsr_reg[0] ? LFSR_TAPS : '0);
        range_cur = RANGE_W'(vt_cur) * RANGE_W'(RANGE_MUL);
        base_mul  = RANGE_W'(vt_cur) * RANGE_W'(BASE_MUL);
        base      = (base_mul < RANGE_W'(BASE_MIN)) ? RANGE_W'(BASE_MIN) : base_mul;
        reload    = CD_W'(base) + CD_W'(rnd);
        wr_idx    = (act == A_INSERT) ? free_idx_reg : idx_reg;
        out_free  = !res_valid_reg || !result_stall;

        st.item_valid = item_valid;
        st.out_free   = out_free;
        st.div_busy   = div_busy;
        st.f_tick     = (func_reg == FN_TICK);
        st.f_en       = (func_reg == FN_ENABLE);
        st.f_dis      = (func_reg == FN_DISABLE);
        st.f_rs       = (func_reg == FN_READV) || (func_reg == FN_DISCOVER);
        st.due        = u_cur && (cd_cur == '0) && (nres_reg < NRES_W'(MAX_RES));
        st.last_slot  = (idx_reg == IDX_W'(ENTRIES - 1));
        st.rs_skip    = !(u_cur && ((id_reg == '0) || (e_cur == id_reg)));
        st.hit        = match;
        st.found      = found_reg;
        st.no_free    = !free_found_reg;
    end

    adp_mod_unit u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (act == A_DRAW),
        .dividend  (lfsr_step),
        .divisor   (range_cur),
        .busy      (div_busy),
        .remainder (rnd)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            nres_reg       <= '0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            slot_used_reg  <= '0;
            lfsr_reg       <= SEED_RESET;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (seed_wr)
                lfsr_reg <= seed_val;
            else if (act == A_DRAW)
                lfsr_reg <= lfsr_step;

            case (act)
                A_ACCEPT:
                begin
                    idx_reg        <= '0;
                    nres_reg       <= '0;
                    found_reg      <= 1'b0;
                    free_found_reg <= 1'b0;
                end
                A_INC_IDX:
                    idx_reg <= idx_reg + 1'b1;
                A_EMIT_AV:
                    nres_reg <= nres_reg + 1'b1;
                A_SCAN:
                begin
                    if (match)
                        found_reg <= 1'b1;
                    if (!u_cur)
                        free_found_reg <= 1'b1;
                end
                A_INSERT:
                    slot_used_reg[free_idx_reg] <= 1'b1;
                A_EMIT_DEP:
                    slot_used_reg[idx_reg] <= 1'b0;
                default:
                    ;
            endcase

            if ((act == A_EMIT_AV) || (act == A_EMIT_FULL) || (act == A_EMIT_DEP))
                res_valid_reg <= 1'b1;
            else if (!result_stall)
                res_valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        case (act)
            A_ACCEPT:
            begin
                func_reg <= func;
                id_reg   <= entity_id;
                vt_reg   <= valid_time;
            end
            A_DEC:
                if (u_cur && (cd_cur != '0))
                    slot_cd_reg[wr_idx] <= cd_cur - 1'b1;
            A_RELOAD:
                slot_cd_reg[wr_idx] <= reload;
            A_LOAD_RAND:
                slot_cd_reg[wr_idx] <= CD_W'(rnd);
            A_SCAN:
                if (!u_cur && !free_found_reg)
                    free_idx_reg <= idx_reg;
            A_INSERT:
            begin
                slot_entity_reg[wr_idx] <= id_reg;
                slot_vt_reg[wr_idx]     <= vt_reg;
                slot_cd_reg[wr_idx]     <= '0;
            end
            A_EMIT_AV:
            begin
                res_kind_reg <= KIND_AVAIL;
                res_id_reg   <= e_cur;
                res_vt_reg   <= vt_cur;
                res_last_reg <= av_last;
            end
            A_EMIT_DEP:
            begin
                res_kind_reg <= KIND_DEPART;
                res_id_reg   <= e_cur;
                res_vt_reg   <= vt_cur;
                res_last_reg <= 1'b1;
            end
            A_EMIT_FULL:
            begin
                res_kind_reg <= KIND_FULL;
                res_id_reg   <= id_reg;
                res_vt_reg   <= vt_reg;
                res_last_reg <= 1'b1;
            end
            default:
                ;
        endcase
    end

    assign result_valid   = res_valid_reg;
    assign message_kind   = res_kind_reg;
    assign out_entity_id  = res_id_reg;
    assign out_valid_time = res_vt_reg;
    assign last_result    = res_last_reg;

endmodule

`default_nettype wire

/* rtl/core/adp_chk.sv */
// Port-level checker for the ADP advertise scheduler, bound to the top level.
// Depends on adp_pkg and adp_advertise_scheduler_core.
`default_nettype none

module adp_chk (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [adp_pkg::PADDR_W-1:0] paddr,
    input  wire logic [adp_pkg::PDATA_W-1:0] pwdata,
    input  wire logic [adp_pkg::PDATA_W-1:0] prdata,
    input  wire logic                        pready,
    input  wire logic                        result_valid,
    input  wire logic                        result_stall,
    input  wire logic [adp_pkg::KIND_W-1:0]  message_kind,
    input  wire logic [adp_pkg::ID_W-1:0]    out_entity_id,
    input  wire logic [adp_pkg::VT_W-1:0]    out_valid_time,
    input  wire logic                        last_result
);
    import adp_pkg::*;

    // stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(message_kind)
            && $stable(out_entity_id) && $stable(out_valid_time) && $stable(last_result))
        else $error("stalled result changed");

    // every result carries a real message kind
    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> message_kind != KIND_NONE)
        else $error("result with empty message kind");

    // departing and table-full are single-result transactions
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (message_kind == KIND_DEPART || message_kind == KIND_FULL)
            |-> last_result)
        else $error("single-result transaction not marked last");

    // seed write reads back
    a_seed_rb: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready && (paddr[PADDR_W-1] == REG_SEED)
            |=> (paddr[PADDR_W-1] != REG_SEED)
                || (prdata[LFSR_W-1:0] == $past(pwdata[LFSR_W-1:0])))
        else $error("seed register read-back mismatch");

endmodule

bind adp_advertise_scheduler_core adp_chk u_chk (.*);

`default_nettype wire

/* tb/tb.sv */
// Self-checking testbench for adp_advertise_scheduler_core: slot table, tick scan,
// enable/disable/readvertise/discover, LFSR random delay and the APB seed register.
// Depends on adp_pkg and the RTL of the block only.
`timescale 1ns / 100ps

module tb;
    import adp_pkg::*;

    // Sender idle / receiver stall percentages used by the phases
    localparam int IDLE_HEAVY     = 72;
    localparam int IDLE_LIGHT     = 7;
    // Long receiver hold-off that backs results up into the item channel
    localparam int HOLD_CYCLES    = 600;
    // Cycles to let a result-less transaction finish its slot scan
    localparam int SETTLE_CYCLES  = 400;
    // Cycles with no transaction on either channel before giving up
    localparam int WATCHDOG_LIMIT = 5000;
    // Countdowns at or below this are run down by a burst of ticks
    localparam int BURST_MAX      = 40;
    localparam int POOL_SIZE      = 12;

    // Function codes the block ignores
    localparam logic [FUNC_W-1:0] FN_SPARE_FIRST = 3'd5;
    localparam logic [FUNC_W-1:0] FN_SPARE_LAST  = 3'd7;

    localparam logic [PADDR_W-1:0] SEED_ADDR = PADDR_W'(int'(REG_SEED) * 4);

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   id;
        logic [VT_W-1:0]   vt;
        logic              last;
    } adv_msg_t;

    // Scoreboard: keeps its own copy of the entity table and the LFSR, turns each
    // accepted transaction into the messages it must produce, and checks the
    // result channel against them in order.
    class adv_scoreboard;
        bit                used[ENTRIES];
        logic [ID_W-1:0]   ent[ENTRIES];
        logic [VT_W-1:0]   vt_r[ENTRIES];
        logic [CD_W-1:0]   cd[ENTRIES];
        logic [LFSR_W-1:0] lfsr;
        adv_msg_t          awaited_msgs[$];
        int                errors;
        int                n_commands;
        int                n_available;
        int                n_departing;
        int                n_full;

        function new();
            foreach (used[i])
            begin
                used[i] = 1'b0;
                ent[i]  = '0;
                vt_r[i] = '0;
                cd[i]   = '0;
            end
            lfsr = SEED_RESET;
        endfunction

        function void load_seed(logic [LFSR_W-1:0] seed);
            lfsr = seed;
        endfunction

        // Galois step, then draw modulo valid_time*400 (zero range -> zero)
        function int random_backoff(logic [VT_W-1:0] v);
            int span;
            span = int'(v) * RANGE_MUL;
            lfsr = lfsr[0] ? ((lfsr >> 1) ^ LFSR_TAPS) : (lfsr >> 1);
            if (span == 0)
                return 0;
            return int'(lfsr) % span;
        endfunction

        function logic [CD_W-1:0] reload_countdown(logic [VT_W-1:0] v);
            int base;
            base = int'(v) * BASE_MUL;
            if (base < BASE_MIN)
                base = BASE_MIN;
            return CD_W'(base + random_backoff(v));
        endfunction

        function int find_entity(logic [ID_W-1:0] id);
            foreach (used[i])
                if (used[i] && ent[i] == id)
                    return i;
            return -1;
        endfunction

        function void accept_command(logic [FUNC_W-1:0] f, logic [ID_W-1:0] id,
                                     logic [VT_W-1:0] v);
            adv_msg_t batch[$];
            int       hit;
            int       free_slot;
            n_commands++;
            case (f)
                FN_TICK:
                    foreach (used[i])
                    begin
                        if (!used[i])
                            continue;
                        if (cd[i] == '0)
                        begin
                            // due entries past the per-tick cap stay due
                            if (batch.size() < MAX_RES)
                            begin
                                batch.push_back('{KIND_AVAIL, ent[i], vt_r[i], 1'b0});
                                cd[i] = reload_countdown(vt_r[i]);
                            end
                        end
                        else
                            cd[i] = cd[i] - 1'b1;
                    end
                FN_ENABLE:
                    if (find_entity(id) < 0)
                    begin
                        free_slot = -1;
                        foreach (used[i])
                            if (!used[i] && free_slot < 0)
                                free_slot = i;
                        if (free_slot < 0)
                            batch.push_back('{KIND_FULL, id, v, 1'b0});
                        else
                        begin
                            used[free_slot] = 1'b1;
                            ent[free_slot]  = id;
                            vt_r[free_slot] = v;
                            cd[free_slot]   = '0;
                        end
                    end
                FN_DISABLE:
                begin
                    hit = find_entity(id);
                    if (hit >= 0)
                    begin
                        batch.push_back('{KIND_DEPART, ent[hit], vt_r[hit], 1'b0});
                        used[hit] = 1'b0;
                    end
                end
                FN_READV, FN_DISCOVER:
                    foreach (used[i])
                        if (used[i] && (id == '0 || ent[i] == id))
                            cd[i] = CD_W'(random_backoff(vt_r[i]));
                default: ;
            endcase
            if (batch.size() > 0)
                batch[batch.size() - 1].last = 1'b1;
            foreach (batch[k])
                awaited_msgs.push_back(batch[k]);
        endfunction

        function void match_message(logic [KIND_W-1:0] kind, logic [ID_W-1:0] id,
                                    logic [VT_W-1:0] v, logic last);
            adv_msg_t want;
            if (awaited_msgs.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result: expected none, got kind %0d id %h vt %0d",
                         $time, kind, id, v);
                return;
            end
            want = awaited_msgs.pop_front();
            case (kind)
                KIND_AVAIL:  n_available++;
                KIND_DEPART: n_departing++;
                KIND_FULL:   n_full++;
                default: ;
            endcase
            if (kind !== want.kind)
            begin
                errors++;
                $display("%0t: message_kind expected %0d, got %0d", $time, want.kind, kind);
            end
            if (id !== want.id)
            begin
                errors++;
                $display("%0t: out_entity_id expected %h, got %h", $time, want.id, id);
            end
            if (v !== want.vt)
            begin
                errors++;
                $display("%0t: out_valid_time expected %0d, got %0d", $time, want.vt, v);
            end
            if (last !== want.last)
            begin
                errors++;
                $display("%0t: last_result expected %0d, got %0d", $time, want.last, last);
            end
        endfunction

        function int pending();
            return awaited_msgs.size();
        endfunction

        // Smallest nonzero countdown among stored entities, 0 if there is none
        function int soonest_countdown();
            int best;
            best = 0;
            foreach (used[i])
                if (used[i] && cd[i] != '0 && (best == 0 || int'(cd[i]) < best))
                    best = int'(cd[i]);
            return best;
        endfunction

        // Id of a random stored entity, or 'fallback' when the table is empty
        function logic [ID_W-1:0] stored_id(logic [ID_W-1:0] fallback);
            int held[$];
            foreach (used[i])
                if (used[i])
                    held.push_back(i);
            if (held.size() == 0)
                return fallback;
            return ent[held[$urandom_range(0, held.size() - 1)]];
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                item_valid;
    logic                item_stall;
    logic [FUNC_W-1:0]   func;
    logic [ID_W-1:0]     entity_id;
    logic [VT_W-1:0]     valid_time;
    logic                result_valid;
    logic                result_stall;
    logic [KIND_W-1:0]   message_kind;
    logic [ID_W-1:0]     out_entity_id;
    logic [VT_W-1:0]     out_valid_time;
    logic                last_result;

    adv_scoreboard       sb;
    logic [ID_W-1:0]     id_pool[POOL_SIZE];
    int                  idle_pct;
    int                  stall_pct;
    int                  hold_left;
    int                  seeds_written;
    int                  quiet;

    adp_advertise_scheduler_core u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .func           (func),
        .entity_id      (entity_id),
        .valid_time     (valid_time),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .message_kind   (message_kind),
        .out_entity_id  (out_entity_id),
        .out_valid_time (out_valid_time),
        .last_result    (last_result)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Result side: random stalls at the phase's rate, or a long hold-off while
    // hold_left is counting down. Driven at the falling edge.
    initial
    begin
        result_stall = 1'b0;
        hold_left    = 0;
        stall_pct    = 0;
    end

    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            result_stall <= 1'b1;
            hold_left--;
        end
        else
            result_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Monitor: every transaction on either channel is seen at the rising edge,
    // before the block's own updates land.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && !item_stall)
                sb.accept_command(func, entity_id, valid_time);
            if (result_valid && !result_stall)
                sb.match_message(message_kind, out_entity_id, out_valid_time, last_result);
        end
    end

    // Watchdog: a hung block (no transaction either way for too long) ends the run
    initial
    begin
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("adp_advertise_scheduler_core: mismatch");
        $finish;
    end

    function automatic logic [ID_W-1:0] random_id();
        return {$urandom, $urandom};
    endfunction

    // Offer one transaction, with random idle cycles ahead of it, and hold it
    // until the block takes it. Returns at the accepting rising edge.
    task automatic send_item(input logic [FUNC_W-1:0] f, input logic [ID_W-1:0] id,
                             input logic [VT_W-1:0] v);
        @(negedge clk);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            item_valid <= 1'b0;
            do
                @(negedge clk);
            while ($urandom_range(0, 99) < idle_pct);
        end
        item_valid <= 1'b1;
        func       <= f;
        entity_id  <= id;
        valid_time <= v;
        do
            @(posedge clk);
        while (item_stall);
    endtask

    // Stop offering, wait for every awaited message, then let a trailing
    // result-less scan run out before touching the configuration.
    task automatic quiesce();
        @(negedge clk);
        item_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_cycle(input logic wr, input logic [PDATA_W-1:0] data,
                             output logic [PDATA_W-1:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= SEED_ADDR;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_seed(input logic [LFSR_W-1:0] want);
        logic [PDATA_W-1:0] rd;
        apb_cycle(1'b0, '0, rd);
        if (rd[LFSR_W-1:0] !== want)
        begin
            sb.errors++;
            $display("%0t: random_seed readback expected %h, got %h", $time, want,
                     rd[LFSR_W-1:0]);
        end
    endtask

    task automatic reseed(input logic [LFSR_W-1:0] seed);
        logic [PDATA_W-1:0] rd;
        apb_cycle(1'b1, PDATA_W'(seed), rd);
        sb.load_seed(seed);
        seeds_written++;
        check_seed(seed);
    endtask

    // Random traffic. Mostly well-formed: disables and targeted reschedules
    // go to entities that are actually stored, enables draw from a small id
    // pool so the table fills up and known ids get re-enabled. When a stored
    // countdown is short, a burst of ticks runs it down to expiry.
    task automatic run_random(input int count);
        int              sent;
        int              pick;
        int              gap;
        logic [ID_W-1:0] id;
        logic [VT_W-1:0] v;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(0, 99);
            id   = sb.stored_id(id_pool[$urandom_range(0, POOL_SIZE - 1)]);
            v    = $urandom_range(0, 1) ? VT_W'($urandom_range(0, 2))
                                        : VT_W'($urandom_range(0, 31));
            gap  = sb.soonest_countdown();
            if (pick < 6 && gap > 0 && gap <= BURST_MAX)
            begin
                repeat (gap + 1) send_item(FN_TICK, random_id(), v);
                sent += gap + 1;
            end
            else
            begin
                if (pick < 44)
                    send_item(FN_TICK, random_id(), v);
                else if (pick < 54)
                    send_item(FN_ENABLE, id_pool[$urandom_range(0, POOL_SIZE - 1)], v);
                else if (pick < 60)
                    send_item(FN_ENABLE, random_id(), v);
                else if (pick < 64)
                    send_item(FN_ENABLE, id, v);
                else if (pick < 74)
                    send_item(FN_DISABLE, id, v);
                else if (pick < 76)
                    send_item(FN_DISABLE, random_id(), v);
                else if (pick < 84)
                    send_item(FN_READV, ($urandom_range(0, 2) == 0) ? '0 : id, v);
                else if (pick < 92)
                    send_item(FN_DISCOVER, ($urandom_range(0, 2) == 0) ? '0 : id, v);
                else if (pick < 96)
                    send_item(FUNC_W'($urandom_range(FN_SPARE_FIRST, FN_SPARE_LAST)),
                              random_id(), v);
                else
                    send_item(FN_READV, random_id(), v);
                sent++;
            end
        end
    endtask

    initial
    begin
        logic [ID_W-1:0] unknown_id;

        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        item_valid    <= 1'b0;
        func          <= FN_TICK;
        entity_id     <= '0;
        valid_time    <= '0;
        rst_n         <= 1'b0;
        idle_pct      = 0;
        seeds_written = 0;
        sb            = new();

        // Ids of the directed part go into the enable pool as well
        id_pool[0] = '1;
        id_pool[1] = '0;
        id_pool[2] = 64'h5555_5555_5555_5555;
        id_pool[3] = 64'hAAAA_AAAA_AAAA_AAAA;
        id_pool[4] = 64'h8000_0000_0000_0001;
        for (int i = 5; i < POOL_SIZE; i++)
            id_pool[i] = random_id();
        unknown_id = random_id();

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Seed register comes out of reset at its documented value
        check_seed(SEED_RESET);

        // ---- Directed part, reset seed, no idling ----
        // Tick on an empty table: no messages
        send_item(FN_TICK, '0, '0);
        // Fill all eight slots: id and valid_time extremes, zero valid time
        send_item(FN_ENABLE, id_pool[0], 5'd31);
        send_item(FN_ENABLE, id_pool[1], 5'd0);
        send_item(FN_ENABLE, id_pool[2], 5'd1);
        send_item(FN_ENABLE, id_pool[3], 5'd16);
        send_item(FN_ENABLE, id_pool[4], 5'd0);
        send_item(FN_ENABLE, id_pool[5], 5'd2);
        send_item(FN_ENABLE, id_pool[6], 5'd15);
        send_item(FN_ENABLE, id_pool[7], 5'd0);
        // Re-enable of a stored id is ignored and keeps the stored valid time
        send_item(FN_ENABLE, id_pool[0], 5'd5);
        // Table full
        send_item(FN_ENABLE, unknown_id, 5'd31);
        // All eight are due at once: a full tick of available messages
        send_item(FN_TICK, '1, 5'd31);
        send_item(FN_TICK, '0, '0);
        // Readvertise all: zero valid time entries become due straight away
        send_item(FN_READV, '0, '0);
        send_item(FN_TICK, '0, '0);
        send_item(FN_DISCOVER, id_pool[4], '0);
        send_item(FN_TICK, '0, '0);
        // Departing message, then disable/readvertise of an unknown id
        send_item(FN_DISABLE, id_pool[0], '0);
        send_item(FN_DISABLE, unknown_id, '0);
        send_item(FN_READV, unknown_id, '0);
        // Reserved function codes are ignored
        for (int c = FN_SPARE_FIRST; c <= FN_SPARE_LAST; c++)
            send_item(FUNC_W'(c), random_id(), VT_W'($urandom_range(0, 31)));
        // Freed slot is reused and due at once
        send_item(FN_ENABLE, unknown_id, 5'd31);
        send_item(FN_TICK, '0, '0);

        // ---- Random phases, each with its own seed and idling ----
        // Lowest nonzero seed, no idling
        quiesce();
        reseed(16'h0001);
        run_random(20);

        // Highest seed, sender mostly idle
        quiesce();
        reseed(16'hFFFF);
        idle_pct = IDLE_HEAVY;
        run_random(20);

        // Zero seed (LFSR stuck at zero, every delay zero), receiver mostly stalled
        quiesce();
        reseed(16'h0000);
        idle_pct  = 0;
        stall_pct = IDLE_HEAVY;
        run_random(20);

        // Back-pressure: receiver holds off for a long stretch while the sender
        // keeps offering. Fresh enables plus a tick make sure messages pile up.
        quiesce();
        reseed(LFSR_W'($urandom_range(1, 65534)));
        stall_pct = 0;
        hold_left = HOLD_CYCLES;
        send_item(FN_ENABLE, random_id(), 5'd0);
        send_item(FN_ENABLE, random_id(), 5'd0);
        send_item(FN_TICK, '0, '0);
        run_random(15);

        // Light idling on both sides
        quiesce();
        reseed(LFSR_W'($urandom_range(1, 65534)));
        idle_pct  = IDLE_LIGHT;
        stall_pct = IDLE_LIGHT;
        run_random(25);

        quiesce();

        $display("run: %0d transactions in, %0d available / %0d departing / %0d table full out",
                 sb.n_commands, sb.n_available, sb.n_departing, sb.n_full);
        $display("run: %0d seed writes, sender/receiver idling 0/%0d/%0d percent, long hold-off",
                 seeds_written, IDLE_LIGHT, IDLE_HEAVY);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("adp_advertise_scheduler_core: match");
        else
            $display("adp_advertise_scheduler_core: mismatch");
        $finish;
    end

endmodule
